// ----- sv/hsb_pkg.sv -----
package hsb_pkg;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 16;
    localparam int SLOT_W = KEY_W + 1;   // key plus valid mark

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    // any other code only looks the key up

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_RESP
    } back_state_t;

endpackage

// ----- sv/hash_set_bucketed_core.sv -----
// Bucketed hash set: insert, remove or find a 16-bit key.
// Slave stream s_*: one request per transaction, tdata = {key, op}
// (op 0 insert, 1 remove, 2 find; 3 acts as find).
// Master stream m_*: one response per request, in request order,
// tdata[0] = key was present before the request, tdata[1] = insert dropped
// because the bucket already held WAYS keys.
// The bucket is key*key mod BUCKETS, worked out in a five-stage front
// pipeline with no divider; requests then wait in a four-entry queue.
// The back end reads one bucket row, then writes it back and registers the
// response; it handles one request at a time and pops the next only after
// that write of the row memory.
// After reset the row memory is swept clear, one bucket per cycle, and
// s_tready stays low until the sweep ends.
// A stalled m_tready holds the response in its output register; the queue
// and front pipeline keep taking requests until they fill, then s_tready
// drops.
module hash_set_bucketed_core
    import hsb_pkg::*;
#(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] op, [17:2] key, [23:18] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] found, [1] status, [7:2] zero
);

    localparam int BW = $clog2(BUCKETS);
    localparam int QW = OP_W + KEY_W + BW;

    logic          hold;
    logic          push;
    req_t          push_req;
    logic [BW-1:0] push_bucket;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;
    req_t          pop_req;
    logic [BW-1:0] pop_bucket;

    hsb_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .hold        (hold),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push        (push),
        .push_req    (push_req),
        .push_bucket (push_bucket),
        .full        (q_full)
    );

    assign q_wdata = {push_req, push_bucket};

    hsb_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign pop_req    = q_rdata[QW-1:BW];
    assign pop_bucket = q_rdata[BW-1:0];

    hsb_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .busy     (hold),
        .empty    (q_empty),
        .pop      (q_pop),
        .req      (pop_req),
        .bucket   (pop_bucket),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/hsb_fifo.sv -----
module hsb_fifo
    import hsb_pkg::*;
#(
    parameter int WIDTH = 22
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0]  mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/hsb_front.sv -----
module hsb_front
    import hsb_pkg::*;
#(
    parameter int BUCKETS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       hold,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // [1:0] op, [17:2] key
    output logic                       push,
    output req_t                       push_req,
    output logic [$clog2(BUCKETS)-1:0] push_bucket,
    input  logic                       full
);

    localparam int BW = $clog2(BUCKETS);

    // remainder by BUCKETS through a reciprocal: q = (n * M) >> (N + BW) is exact
    localparam int M1W  = KEY_W + 2;
    localparam int P1W  = KEY_W + M1W;
    localparam int QB1W = KEY_W + BW + 1;
    localparam logic [63:0] M1_FULL = (64'd1 << (KEY_W + BW)) / BUCKETS + 64'd1;

    localparam int N2   = 2 * BW;
    localparam int M2W  = N2 + 2;
    localparam int P2W  = N2 + M2W;
    localparam int QB2W = N2 + BW + 1;
    localparam logic [63:0] M2_FULL = (64'd1 << (N2 + BW)) / BUCKETS + 64'd1;

    logic en;
    logic accept;

    logic [5:1]      v_reg;
    logic [OP_W-1:0] op_reg  [1:5];
    logic [KEY_W-1:0] key_reg [1:5];

    logic [P1W-1:0]   prod1_reg, prod1_next;
    logic [KEY_W-1:0] qb1_reg, qb1_next;
    logic [N2-1:0]    sq_reg [3:5];
    logic [N2-1:0]    sq_next;
    logic [P2W-1:0]   prod2_reg, prod2_next;
    logic [N2-1:0]    qb2_reg, qb2_next;

    logic [P1W-1:0]   q1_full;
    logic [KEY_W-1:0] q1;
    logic [QB1W-1:0]  qb1_full;
    logic [KEY_W-1:0] r1_diff;
    logic [BW-1:0]    r1;
    logic [P2W-1:0]   q2_full;
    logic [N2-1:0]    q2;
    logic [QB2W-1:0]  qb2_full;
    logic [N2-1:0]    r2_diff;

    // whole pipeline steps together; it waits while the back end clears its rows or when the last stage cannot drain
    assign en       = !hold && !(v_reg[5] && full);
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign prod1_next = P1W'(s_tdata[OP_W +: KEY_W]) * P1W'(M1_FULL[M1W-1:0]);

    assign q1_full  = prod1_reg >> (KEY_W + BW);
    assign q1       = q1_full[KEY_W-1:0];
    assign qb1_full = QB1W'(q1) * QB1W'(BUCKETS);
    assign qb1_next = qb1_full[KEY_W-1:0];

    assign r1_diff  = key_reg[2] - qb1_reg;
    assign r1       = r1_diff[BW-1:0];
    assign sq_next  = N2'(r1) * N2'(r1);

    assign prod2_next = P2W'(sq_reg[3]) * P2W'(M2_FULL[M2W-1:0]);

    assign q2_full  = prod2_reg >> (N2 + BW);
    assign q2       = q2_full[N2-1:0];
    assign qb2_full = QB2W'(q2) * QB2W'(BUCKETS);
    assign qb2_next = qb2_full[N2-1:0];

    assign r2_diff     = sq_reg[5] - qb2_reg;
    assign push        = en && v_reg[5];
    assign push_bucket = r2_diff[BW-1:0];
    assign push_req.op  = op_reg[5];
    assign push_req.key = key_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:1], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[1]  <= s_tdata[OP_W-1:0];
            key_reg[1] <= s_tdata[OP_W +: KEY_W];
            for (int i = 2; i <= 5; i++)
            begin
                op_reg[i]  <= op_reg[i-1];
                key_reg[i] <= key_reg[i-1];
            end
            prod1_reg <= prod1_next;
            qb1_reg   <= qb1_next;
            sq_reg[3] <= sq_next;
            sq_reg[4] <= sq_reg[3];
            sq_reg[5] <= sq_reg[4];
            prod2_reg <= prod2_next;
            qb2_reg   <= qb2_next;
        end
    end

endmodule

// ----- sv/hsb_back.sv -----
module hsb_back
    import hsb_pkg::*;
#(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    output logic                       busy,
    input  logic                       empty,
    output logic                       pop,
    input  req_t                       req,
    input  logic [$clog2(BUCKETS)-1:0] bucket,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata    // [0] found, [1] status
);

    localparam int BW   = $clog2(BUCKETS);
    localparam int ROWW = WAYS * SLOT_W;

    back_state_t st_reg, st_next;

    logic [ROWW-1:0]  mem [BUCKETS];
    logic [ROWW-1:0]  rd_row_reg;
    logic [BW-1:0]    clr_reg, clr_next;
    logic [OP_W-1:0]  cur_op_reg;
    logic [KEY_W-1:0] cur_key_reg;
    logic [BW-1:0]    cur_bkt_reg;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg;
    logic             status_reg;

    logic             mem_we;
    logic [BW-1:0]    mem_waddr;
    logic [ROWW-1:0]  mem_wdata;
    logic             rd_en;
    logic             res_load;
    logic             clr_last;
    logic             out_free;

    logic [WAYS-1:0]  hit_vec;
    logic [WAYS-1:0]  free_sel;
    logic             hit_any;
    logic             free_any;
    logic             is_ins;
    logic             is_rem;
    logic             drop;
    logic [ROWW-1:0]  new_row;

    assign clr_last = (clr_reg == BW'(BUCKETS - 1));
    assign out_free = !out_valid_reg || m_tready;
    assign busy     = (st_reg == ST_CLEAR);
    assign is_ins   = (cur_op_reg == OP_INSERT);
    assign is_rem   = (cur_op_reg == OP_REMOVE);

    always_comb
    begin
        hit_vec  = '0;
        free_sel = '0;
        free_any = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w] = rd_row_reg[w*SLOT_W + KEY_W]
                         && (rd_row_reg[w*SLOT_W +: KEY_W] == cur_key_reg);
            if (!rd_row_reg[w*SLOT_W + KEY_W] && !free_any)
            begin
                free_sel[w] = 1'b1;
                free_any    = 1'b1;
            end
        end
        hit_any = |hit_vec;
        drop    = is_ins && !hit_any && !free_any;
    end

    always_comb
    begin
        new_row = rd_row_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (is_ins && !hit_any && free_sel[w])
            begin
                new_row[w*SLOT_W +: SLOT_W] = {1'b1, cur_key_reg};
            end
            if (is_rem && hit_vec[w])
            begin
                new_row[w*SLOT_W + KEY_W] = 1'b0;
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    st_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (!empty)
                begin
                    st_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    st_next = ST_FETCH;
                end
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_bkt_reg;
        mem_wdata = new_row;
        rd_en     = 1'b0;
        pop       = 1'b0;
        res_load  = 1'b0;
        clr_next  = clr_reg;
        unique case (st_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_FETCH:
            begin
                pop   = !empty;
                rd_en = !empty;
            end
            ST_RESP:
            begin
                mem_we   = out_free;
                res_load = out_free;
            end
            default:
            begin
                clr_next = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_op_reg  <= req.op;
            cur_key_reg <= req.key;
            cur_bkt_reg <= bucket;
        end
        if (res_load)
        begin
            found_reg  <= hit_any;
            status_reg <= drop;
        end
    end

    // bucket rows: keys with valid marks, one row per bucket
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[bucket];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, status_reg, found_reg};

endmodule
